// ----- sv/gini_sparsity_index_unit_assert.svh -----
// assertion macros for the gini sparsity index unit
// used by the checker module only
`ifndef GINI_SPARSITY_INDEX_UNIT_ASSERT_SVH
`define GINI_SPARSITY_INDEX_UNIT_ASSERT_SVH
// implication checked on every rising clock edge outside reset
`define GSI_ASSERT_IMP(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("gsi check failed");
// next-cycle implication
`define GSI_ASSERT_NXT(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("gsi check failed");
`endif

// ----- sv/gsi_pkg.sv -----
// shared types and constants for the gini sparsity index unit
// no dependencies
package gsi_pkg;
  localparam int unsigned FRAC_BITS = 16;
  localparam int unsigned LEN_OUT_BITS = 10;

  // controller to datapath commands
  typedef struct packed {
    logic load;       // store one input beat
    logic clr_blk;    // clear block counters
    logic srt_init;   // start insertion sort
    logic srt_rd;     // issue read of j-1
    logic srt_cmp;    // compare / shift step
    logic srt_place;  // write v at j
    logic srt_next;   // start inner pass at j = i, read store[i]
    logic acc_init;
    logic acc_rd;
    logic acc_step;
    logic div_init;
    logic div_step;
    logic res_load;
  } gsi_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic srt_done;
    logic shift_go;   // j>0 and store[j-1] > v
    logic acc_last;
    logic div_done;
    logic zero_blk;
  } gsi_sts_t;
endpackage

// ----- sv/gsi_ctrl.sv -----
// controller for the gini sparsity index unit
// depends on gsi_pkg
module gsi_ctrl
  import gsi_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  logic     in_last,
  output logic     out_valid,
  input  logic     out_ready,
  input  gsi_sts_t sts,
  output gsi_cmd_t cmd
);
  localparam logic [3:0] S_LOAD  = 4'd0;
  localparam logic [3:0] S_SINIT = 4'd1;
  localparam logic [3:0] S_SRD   = 4'd2;
  localparam logic [3:0] S_SCMP  = 4'd3;
  localparam logic [3:0] S_SNEXT = 4'd4;
  localparam logic [3:0] S_ARD   = 4'd5;
  localparam logic [3:0] S_AST   = 4'd6;
  localparam logic [3:0] S_DIV   = 4'd7;
  localparam logic [3:0] S_RES   = 4'd8;
  localparam logic [3:0] S_SWAIT = 4'd9;
  localparam logic [3:0] S_AWAIT = 4'd10;

  logic [3:0] state_r, state_nxt;
  logic       ovalid_r, ovalid_nxt;

  assign out_valid = ovalid_r;
  assign in_ready  = (state_r == S_LOAD);

  always_comb begin
    state_nxt  = state_r;
    ovalid_nxt = ovalid_r && !out_ready;
    cmd        = '0;
    unique case (state_r)
      S_LOAD: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          if (in_last) state_nxt = S_SINIT;
        end
      end
      S_SINIT: begin
        cmd.srt_init = 1'b1;
        state_nxt = S_SNEXT;
      end
      S_SNEXT: begin
        // sts.srt_done looks at outer index
        if (sts.zero_blk) state_nxt = S_RES;
        else if (sts.srt_done) begin
          cmd.acc_init = 1'b1;
          state_nxt = S_ARD;
        end else begin
          cmd.srt_next = 1'b1;
          state_nxt = S_SRD;
        end
      end
      S_SRD: begin
        cmd.srt_rd = 1'b1;
        state_nxt = S_SWAIT;
      end
      S_SWAIT: state_nxt = S_SCMP;
      S_SCMP: begin
        if (sts.shift_go) begin
          cmd.srt_cmp = 1'b1;
          state_nxt = S_SRD;
        end else begin
          cmd.srt_place = 1'b1;
          state_nxt = S_SNEXT;
        end
      end
      S_ARD: begin
        cmd.acc_rd = 1'b1;
        state_nxt = S_AWAIT;
      end
      S_AWAIT: state_nxt = S_AST;
      S_AST: begin
        cmd.acc_step = 1'b1;
        if (sts.acc_last) begin
          cmd.div_init = 1'b1;
          state_nxt = S_DIV;
        end else state_nxt = S_ARD;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_done) state_nxt = S_RES;
      end
      S_RES: begin
        if (!ovalid_r || out_ready) begin
          cmd.res_load = 1'b1;
          cmd.clr_blk  = 1'b1;
          ovalid_nxt   = 1'b1;
          state_nxt    = S_LOAD;
        end
      end
      default: state_nxt = S_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_LOAD;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end
endmodule

// ----- sv/gsi_dp.sv -----
// datapath: magnitude store, insertion sort, weighted sums, divider
// depends on gsi_pkg
module gsi_dp
  import gsi_pkg::*;
#(
  parameter int MAX_LEN     = 512,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  gsi_cmd_t               cmd,
  output gsi_sts_t               sts,
  input  logic [SAMPLE_BITS-1:0] in_sample,
  output logic [FRAC_BITS-1:0]   out_gini,
  output logic                   out_all_zero,
  output logic                   out_too_long,
  output logic [LEN_OUT_BITS-1:0] out_block_length
);
  localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int CW = $clog2(MAX_LEN + 1);
  localparam int MW = SAMPLE_BITS;
  localparam int TW = MW + CW;
  localparam int WW = CW + 2;
  localparam int SW = TW + WW;
  localparam int DW = TW + CW;
  localparam int RW = (SW > DW ? SW : DW) + 1;
  localparam int QC = $clog2(FRAC_BITS + 1);

  logic [MW-1:0] mem [MAX_LEN];
  logic [MW-1:0] rd_r;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [TW-1:0] tot_r, tot_nxt;
  logic          ovf_r, ovf_nxt;
  logic [CW-1:0] i_r, i_nxt, j_r, j_nxt;
  logic [MW-1:0] v_r, v_nxt;
  logic [SW-1:0] num_r, num_nxt;
  logic [WW-1:0] w_r, w_nxt;
  logic [DW-1:0] den_r;
  logic [RW-1:0] rem_r, rem_nxt;
  logic [FRAC_BITS-1:0] q_r, q_nxt, gini_r;
  logic [QC-1:0] qc_r, qc_nxt;
  logic          zero_r, ovo_r;
  logic [LEN_OUT_BITS-1:0] len_r;
  logic          early_r, early_nxt;
  logic [DW-1:0] den_prod;

  logic [MW-1:0] mag;
  logic          we;
  logic [AW-1:0] wa, ra;
  logic [MW-1:0] wd;
  logic          re;
  logic [RW-1:0] rem_sh;

  assign mag = in_sample[MW-1] ? (~in_sample + 1'b1) : in_sample;

  // single write port and single registered read port
  always_comb begin
    we = 1'b0; wa = '0; wd = mag; re = 1'b0; ra = '0;
    if (cmd.load && cnt_r < CW'(MAX_LEN)) begin
      we = 1'b1; wa = cnt_r[AW-1:0];
    end
    if (cmd.srt_next) begin
      re = 1'b1; ra = i_r[AW-1:0];
    end
    if (cmd.srt_rd) begin
      re = 1'b1; ra = AW'(j_r - 1'b1);
    end
    if (cmd.srt_cmp) begin
      we = 1'b1; wa = j_r[AW-1:0]; wd = rd_r;
    end
    if (cmd.srt_place) begin
      we = 1'b1; wa = j_r[AW-1:0]; wd = v_r;
    end
    if (cmd.acc_rd) begin
      re = 1'b1; ra = i_r[AW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (we) mem[wa] <= wd;
    if (re) rd_r <= mem[ra];
  end

  assign rem_sh = {rem_r[RW-2:0], 1'b0};
  assign den_prod = DW'(cnt_r) * DW'(tot_r);

  always_comb begin
    cnt_nxt = cnt_r; tot_nxt = tot_r; ovf_nxt = ovf_r;
    i_nxt = i_r; j_nxt = j_r; v_nxt = v_r;
    num_nxt = num_r; w_nxt = w_r;
    rem_nxt = rem_r; q_nxt = q_r; qc_nxt = qc_r; early_nxt = early_r;
    if (cmd.load) begin
      if (cnt_r < CW'(MAX_LEN)) begin
        cnt_nxt = cnt_r + 1'b1;
        tot_nxt = tot_r + TW'(mag);
      end else ovf_nxt = 1'b1;
    end
    if (cmd.srt_init) i_nxt = CW'(1);
    if (cmd.srt_next) j_nxt = i_r;
    // first beat after srt_next: v captured in SRD via rd_r below
    if (cmd.srt_rd && j_r == i_r) v_nxt = rd_r;
    if (cmd.srt_cmp) j_nxt = j_r - 1'b1;
    if (cmd.srt_place) i_nxt = i_r + 1'b1;
    if (cmd.acc_init) begin
      i_nxt = '0; num_nxt = '0;
      w_nxt = WW'({cnt_r, 1'b0}) - 1'b1;
    end
    if (cmd.acc_step) begin
      num_nxt = num_r + SW'(rd_r) * SW'(w_r);
      w_nxt = w_r - WW'(2);
      i_nxt = i_r + 1'b1;
    end
    if (cmd.div_init) begin
      qc_nxt = '0; q_nxt = '0;
      early_nxt = (num_nxt >= SW'(den_r));
      rem_nxt = RW'(den_r) - RW'(num_nxt);
    end
    if (cmd.div_step) begin
      q_nxt = {q_r[FRAC_BITS-2:0], 1'b0};
      rem_nxt = rem_sh;
      if (rem_sh >= RW'(den_r)) begin
        rem_nxt = rem_sh - RW'(den_r);
        q_nxt[0] = 1'b1;
      end
      qc_nxt = qc_r + 1'b1;
    end
    if (cmd.clr_blk) begin
      cnt_nxt = '0; tot_nxt = '0; ovf_nxt = 1'b0;
    end
  end

  // v is the value at i; it is read on srt_next and lands in rd_r by SRD
  assign sts.srt_done = (i_r >= cnt_r);
  assign sts.shift_go = (j_r != '0) && (rd_r > v_r) && (j_r != i_r || rd_r > v_nxt);
  assign sts.acc_last = (i_r + 1'b1 >= cnt_r);
  assign sts.div_done = (qc_r == QC'(FRAC_BITS - 1));
  assign sts.zero_blk = (tot_r == '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0; tot_r <= '0; ovf_r <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt; tot_r <= tot_nxt; ovf_r <= ovf_nxt;
    end
    i_r <= i_nxt; j_r <= j_nxt; v_r <= v_nxt;
    num_r <= num_nxt; w_r <= w_nxt;
    rem_r <= rem_nxt; q_r <= q_nxt; qc_r <= qc_nxt; early_r <= early_nxt;
    if (cmd.srt_init) den_r <= den_prod;
    if (cmd.res_load) begin
      gini_r <= ((tot_r == '0) || early_r) ? '0 : q_r;
      zero_r <= (tot_r == '0);
      ovo_r  <= ovf_r;
      len_r  <= LEN_OUT_BITS'(cnt_r);
    end
  end

  assign out_gini = gini_r;
  assign out_all_zero = zero_r;
  assign out_too_long = ovo_r;
  assign out_block_length = len_r;
endmodule

// ----- sv/gini_sparsity_index_unit.sv -----
// gini sparsity index unit: loads a block, insertion sorts it, forms the weighted
// sum and divides once; an all-zero block skips the sort and the division, and
// for other blocks the sort on the single-port store dominates the run time
// one beat per cycle while loading; input held off from last beat until result
// rst_n is synchronous active low, clears the controller and block counters
// memory contents are undefined after reset and need no clearing
module gini_sparsity_index_unit
  import gsi_pkg::*;
#(
  parameter int MAX_LEN     = 512,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [SAMPLE_BITS-1:0]  in_sample,
  input  logic                    in_last,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [FRAC_BITS-1:0]    out_gini,
  output logic                    out_all_zero,
  output logic                    out_too_long,
  output logic [LEN_OUT_BITS-1:0] out_block_length
);
  gsi_cmd_t cmd;
  gsi_sts_t sts;

  gsi_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_ready, .in_last,
    .out_valid, .out_ready, .sts, .cmd
  );

  gsi_dp #(.MAX_LEN(MAX_LEN), .SAMPLE_BITS(SAMPLE_BITS)) u_dp (
    .clk, .rst_n, .cmd, .sts, .in_sample,
    .out_gini, .out_all_zero, .out_too_long, .out_block_length
  );
endmodule

// ----- sv/gsi_chk.sv -----
// port-level checker for the gini sparsity index unit
// depends on gini_sparsity_index_unit_assert.svh
`include "gini_sparsity_index_unit_assert.svh"
module gsi_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] out_gini,
  input logic        out_all_zero
);
  `GSI_ASSERT_IMP(a_zero_gini, out_valid && out_all_zero, out_gini == 16'd0)
  `GSI_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_gini))
  `GSI_ASSERT_NXT(a_res_ends_blk, out_valid && out_ready && in_ready, !out_valid)
endmodule

bind gini_sparsity_index_unit gsi_chk u_gsi_chk (
  .clk, .rst_n, .in_ready, .out_valid, .out_ready,
  .out_gini(out_gini[15:0]), .out_all_zero
);
